// ===== sv/srb_pkg.sv =====
package srb_pkg;

    localparam int IDX_W  = 32;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 7;

    localparam logic [IDX_W-1:0] TOP_INDEX = '1;

endpackage

// ===== sv/stream_byte_reassembler_core.sv =====
// A transaction that delivers no byte passes through the look-up, insert and close states
// and shows its single result, freeing the block in the cycle after. One that completes a run
// of bytes scans the valid-flag memory one slot a cycle, then reads the data memory one byte
// a cycle. Results follow one per cycle and cannot be stalled; busy stays high until the last
// is shown. Synchronous active-low reset clears the counters, then holds busy high while
// every slot of the valid-flag memory is cleared.
module stream_byte_reassembler_core #(
    parameter int CAPACITY = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [srb_pkg::IDX_W-1:0]   i_byte_index,
    input  logic [srb_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                        i_ends_final,
    input  logic                        i_empty_final,
    output logic                        o_strobe,
    output logic                        o_out_valid,
    output logic [srb_pkg::BYTE_W-1:0]  o_out_byte,
    output logic                        o_last_of_run,
    output logic                        o_stream_closed,
    output logic [srb_pkg::CNT_W-1:0]   o_pending_bytes
);

    import srb_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_INS,
        S_SCAN,
        S_CLOSE,
        S_DRAIN
    } t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_idx;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_fin;
    logic                r_empty;
    logic [SLOT_W-1:0]   r_head;
    logic [SLOT_W-1:0]   r_scan;
    logic [CNT_W-1:0]    r_run;
    logic                r_ins;
    logic [IDX_W-1:0]    r_delivered;
    logic [CNT_W-1:0]    r_held;
    logic                r_end_known;
    logic [IDX_W-1:0]    r_end_pos;
    logic                r_closed;
    logic                r_rd_pend;
    logic                r_rd_last;
    logic                r_null_pend;

    logic [IDX_W:0]      diff;
    logic                in_window;
    logic [SLOT_W:0]     slot_sum;
    logic [SLOT_W-1:0]   ins_slot;
    logic                ins_ok;
    logic [IDX_W-1:0]    deliv_sum;
    logic [BYTE_W-1:0]   ram_rdata;
    logic                accept;
    logic [SLOT_W-1:0]   vld_raddr;
    logic [SLOT_W-1:0]   vld_waddr;
    logic                vld_we;
    logic                vld_wdata;
    logic                vld_rdata;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        logic [SLOT_W-1:0] res;
        if (s == SLOT_W'(CAPACITY - 1)) begin
            res = '0;
        end else begin
            res = s + SLOT_W'(1);
        end
        return res;
    endfunction

    assign accept = start && !busy;

    always_comb begin
        diff      = {1'b0, r_idx} - {1'b0, r_delivered};
        in_window = !diff[IDX_W] && (diff[IDX_W-1:0] < IDX_W'(CAPACITY))
                    && (r_idx != TOP_INDEX);
        slot_sum  = {1'b0, r_head} + {1'b0, diff[SLOT_W-1:0]};
        if (slot_sum >= (SLOT_W+1)'(CAPACITY)) begin
            slot_sum = slot_sum - (SLOT_W+1)'(CAPACITY);
        end
        ins_slot  = slot_sum[SLOT_W-1:0];
        ins_ok    = !r_empty && in_window && !vld_rdata;
        deliv_sum = r_delivered + IDX_W'(r_run);
    end

    assign vld_raddr = (r_state == S_LOOK) ? ins_slot :
                       (r_state == S_INS)  ? next_slot(r_head) : r_scan;
    assign vld_we    = (r_state == S_CLEAR) || (r_state == S_INS && ins_ok)
                       || (r_state == S_DRAIN);
    assign vld_waddr = (r_state == S_CLEAR) ? r_scan :
                       (r_state == S_INS)   ? ins_slot : r_head;
    assign vld_wdata = (r_state == S_INS);

    srb_ram #(
        .WIDTH(1),
        .DEPTH(CAPACITY)
    ) u_valid_ram (
        .i_clk  (i_clk),
        .i_we   (vld_we),
        .i_waddr(vld_waddr),
        .i_wdata(vld_wdata),
        .i_raddr(vld_raddr),
        .o_rdata(vld_rdata)
    );

    srb_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(CAPACITY)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (r_state == S_INS && ins_ok),
        .i_waddr(ins_slot),
        .i_wdata(r_byte),
        .i_raddr(r_head),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_head      <= '0;
            r_scan      <= '0;
            r_run       <= '0;
            r_ins       <= 1'b0;
            r_delivered <= '0;
            r_held      <= '0;
            r_end_known <= 1'b0;
            r_end_pos   <= '0;
            r_closed    <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_null_pend <= 1'b0;
        end else begin
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_null_pend <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_scan <= next_slot(r_scan);
                    if (r_scan == SLOT_W'(CAPACITY - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_idx   <= i_byte_index;
                        r_byte  <= i_data_byte;
                        r_fin   <= i_ends_final;
                        r_empty <= i_empty_final;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_state <= S_INS;
                end
                S_INS: begin
                    r_ins <= ins_ok;
                    if (r_empty) begin
                        r_end_known <= 1'b1;
                        r_end_pos   <= r_idx;
                    end else if (r_fin) begin
                        r_end_known <= 1'b1;
                        r_end_pos   <= (r_idx == TOP_INDEX) ? r_idx : r_idx + IDX_W'(1);
                    end
                    if (ins_ok && diff[IDX_W-1:0] == '0) begin
                        r_run   <= CNT_W'(1);
                        r_scan  <= next_slot(next_slot(r_head));
                        r_state <= S_SCAN;
                    end else begin
                        r_run   <= '0;
                        r_state <= S_CLOSE;
                    end
                end
                S_SCAN: begin
                    if (r_run < CNT_W'(CAPACITY) && vld_rdata) begin
                        r_run  <= r_run + CNT_W'(1);
                        r_scan <= next_slot(r_scan);
                    end else begin
                        r_state <= S_CLOSE;
                    end
                end
                S_CLOSE: begin
                    r_delivered <= deliv_sum;
                    r_held      <= r_held + CNT_W'(r_ins) - r_run;
                    if (r_end_known && deliv_sum == r_end_pos) begin
                        r_closed <= 1'b1;
                    end
                    if (r_run == '0) begin
                        r_null_pend <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_head          <= next_slot(r_head);
                    r_run           <= r_run - CNT_W'(1);
                    r_rd_pend       <= 1'b1;
                    r_rd_last       <= (r_run == CNT_W'(1));
                    if (r_run == CNT_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = (r_state != S_IDLE) || r_rd_pend || r_null_pend;
    assign o_strobe        = r_rd_pend || r_null_pend;
    assign o_out_valid     = r_rd_pend;
    assign o_out_byte      = r_rd_pend ? ram_rdata : '0;
    assign o_last_of_run   = r_rd_last || r_null_pend;
    assign o_stream_closed = r_closed;
    assign o_pending_bytes = r_held;

endmodule

// ===== sv/srb_ram.sv =====
module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/tb.sv =====
module tb;
    import srb_pkg::*;

    localparam int WINDOW       = 64;
    localparam int SLOT_W       = $clog2(WINDOW);
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [BYTE_W-1:0] data;
        logic              ends_final;
        logic              empty_final;
    } stream_item_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              closed;
        logic [CNT_W-1:0]  pending;
    } delivery_t;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              start         = 1'b0;
    logic [IDX_W-1:0]  i_byte_index  = '0;
    logic [BYTE_W-1:0] i_data_byte   = '0;
    logic              i_ends_final  = 1'b0;
    logic              i_empty_final = 1'b0;
    logic              busy;
    logic              o_strobe;
    logic              o_out_valid;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_last_of_run;
    logic              o_stream_closed;
    logic [CNT_W-1:0]  o_pending_bytes;

    stream_item_t send_q[$];
    stream_item_t on_bus;
    delivery_t    delivery_q[$];
    delivery_t    oldest;
    int           total_items    = 0;
    int           accepted_items = 0;
    int           failures       = 0;
    int           quiet_cycles   = 0;
    int           idle_pct[4]    = '{0, 80, 0, 28};
    logic [IDX_W-1:0] gen_base   = '0;

    logic [BYTE_W-1:0] win_byte [WINDOW];
    logic [WINDOW-1:0] win_full   = '0;
    logic [SLOT_W-1:0] front_slot = '0;
    logic [IDX_W-1:0]  next_pos   = '0;
    logic [CNT_W-1:0]  held_total = '0;
    logic              eos_known  = 1'b0;
    logic [IDX_W-1:0]  eos_pos    = '0;
    logic              is_closed  = 1'b0;

    always #10 i_clk = ~i_clk;

    stream_byte_reassembler_core #(
        .CAPACITY(WINDOW)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_byte_index(i_byte_index),
        .i_data_byte(i_data_byte),
        .i_ends_final(i_ends_final),
        .i_empty_final(i_empty_final),
        .o_strobe(o_strobe),
        .o_out_valid(o_out_valid),
        .o_out_byte(o_out_byte),
        .o_last_of_run(o_last_of_run),
        .o_stream_closed(o_stream_closed),
        .o_pending_bytes(o_pending_bytes)
    );

    task automatic reassemble_item(input stream_item_t it);
        logic [BYTE_W-1:0] run_bytes[$];
        logic [IDX_W-1:0]  off;
        logic [SLOT_W-1:0] slot;
        delivery_t         d;
        int                k;
        if (it.empty_final) begin
            eos_known = 1'b1;
            eos_pos   = it.index;
        end else begin
            if (it.index != TOP_INDEX && it.index >= next_pos) begin
                off = it.index - next_pos;
                if (off < WINDOW) begin
                    slot = front_slot + off[SLOT_W-1:0];
                    if (!win_full[slot]) begin
                        win_byte[slot] = it.data;
                        win_full[slot] = 1'b1;
                        held_total     = held_total + 1'b1;
                    end
                end
            end
            while (run_bytes.size() < WINDOW && win_full[front_slot]) begin
                run_bytes.push_back(win_byte[front_slot]);
                win_full[front_slot] = 1'b0;
                front_slot = front_slot + 1'b1;
                next_pos   = next_pos + 1;
                held_total = held_total - 1'b1;
            end
            if (it.ends_final) begin
                eos_known = 1'b1;
                eos_pos   = (it.index == TOP_INDEX) ? TOP_INDEX : it.index + 1;
            end
        end
        if (eos_known && next_pos == eos_pos) begin
            is_closed = 1'b1;
        end
        d.closed  = is_closed;
        d.pending = held_total;
        if (run_bytes.size() == 0) begin
            d.valid = 1'b0;
            d.data  = '0;
            d.last  = 1'b1;
            delivery_q.push_back(d);
        end else begin
            for (k = 0; k < run_bytes.size(); k++) begin
                d.valid = 1'b1;
                d.data  = run_bytes[k];
                d.last  = (k == run_bytes.size() - 1);
                delivery_q.push_back(d);
            end
        end
    endtask

    task automatic push_item(input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data,
                             input logic fin, input logic empty);
        stream_item_t it;
        it.index       = idx;
        it.data        = data;
        it.ends_final  = fin;
        it.empty_final = empty;
        send_q.push_back(it);
    endtask

    // A segment covers every position from gen_base on, in random order, so the
    // stream has advanced past it once its last byte is in. Stray bytes land outside the
    // window or repeat a position already sent, and end marks are placed where they cannot
    // close the stream except in the closing segment.
    task automatic add_segment(input int len, input bit closing, input bit front_last);
        logic [IDX_W-1:0] order[$];
        logic [IDX_W-1:0] tmp;
        logic [IDX_W-1:0] pick;
        logic [IDX_W-1:0] low;
        int               j;
        int               k;
        for (k = 0; k < len; k++) begin
            order.push_back(gen_base + k);
        end
        for (k = len - 1; k > 0; k--) begin
            j = $urandom_range(k, 0);
            tmp = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        if (front_last) begin
            for (k = 0; k < len; k++) begin
                if (order[k] == gen_base) begin
                    order[k] = order[len - 1];
                    order[len - 1] = gen_base;
                end
            end
        end
        for (k = 0; k < len; k++) begin
            while ($urandom_range(99) < 15) begin
                pick = $urandom();
                if (pick < gen_base + 128) begin
                    pick = TOP_INDEX;
                end
                low = (gen_base == 0) ? pick : $urandom_range(gen_base - 1, 0);
                case ($urandom_range(4))
                    0: push_item(low, BYTE_W'($urandom()), 1'b0, 1'b0);
                    1: push_item(pick, BYTE_W'($urandom()), !closing && $urandom_range(1),
                                 1'b0);
                    2: push_item((k > 0) ? order[$urandom_range(k - 1, 0)] : pick,
                                 BYTE_W'($urandom()), 1'b0, 1'b0);
                    3: begin
                        if (closing) begin
                            push_item(low, BYTE_W'($urandom()), 1'b0, 1'b0);
                        end else begin
                            push_item($urandom_range(1) ? pick : low, BYTE_W'($urandom()),
                                      1'($urandom_range(1)), 1'b1);
                        end
                    end
                    default: push_item(TOP_INDEX, BYTE_W'($urandom()),
                                       !closing && $urandom_range(1), 1'b0);
                endcase
            end
            push_item(order[k], BYTE_W'($urandom()),
                      closing && order[k] == gen_base + len - 1, 1'b0);
        end
        gen_base = gen_base + len;
    endtask

    initial begin
        int seg_len;
        push_item(0, 8'h00, 1'b0, 1'b0);
        push_item(2, 8'hFF, 1'b0, 1'b0);
        push_item(2, 8'h5A, 1'b0, 1'b0);
        push_item(0, 8'h11, 1'b0, 1'b0);
        push_item(65, 8'h22, 1'b0, 1'b0);
        push_item(64, 8'hA5, 1'b0, 1'b0);
        push_item(TOP_INDEX, 8'h33, 1'b1, 1'b0);
        push_item(32'h8000_0000, 8'h44, 1'b1, 1'b1);
        push_item(3, 8'h66, 1'b0, 1'b1);
        push_item(1, 8'h77, 1'b1, 1'b0);
        push_item(32'h7FFF_FFFF, 8'h88, 1'b1, 1'b0);
        push_item(0, 8'h99, 1'b0, 1'b1);
        push_item(TOP_INDEX, 8'hC3, 1'b0, 1'b1);
        // Position 64 is already held, so the first segment completes a run through it.
        gen_base = 3;
        add_segment(61, 1'b0, 1'b0);
        gen_base = 65;
        add_segment(64, 1'b0, 1'b1);
        while (send_q.size() < 250) begin
            case ($urandom_range(9))
                0: seg_len = $urandom_range(64, 33);
                1, 2: seg_len = $urandom_range(32, 9);
                default: seg_len = $urandom_range(8, 1);
            endcase
            add_segment(seg_len, 1'b0, $urandom_range(3) == 0);
        end
        add_segment($urandom_range(24, 8), 1'b1, 1'b0);
        add_segment($urandom_range(16, 1), 1'b0, 1'b1);
        add_segment($urandom_range(16, 1), 1'b0, 1'b0);
        total_items = send_q.size();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (accepted_items != total_items || delivery_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                reassemble_item(on_bus);
                accepted_items = accepted_items + 1;
            end
            if (!start || !busy) begin
                if (send_q.size() != 0 &&
                    $urandom_range(99) >= idle_pct[(accepted_items * 4) / (total_items + 1)]) begin
                    on_bus = send_q.pop_front();
                    start         <= 1'b1;
                    i_byte_index  <= on_bus.index;
                    i_data_byte   <= on_bus.data;
                    i_ends_final  <= on_bus.ends_final;
                    i_empty_final <= on_bus.empty_final;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (delivery_q.size() == 0) begin
                $display("%0t: unexpected transaction: valid=%0b byte=%02h last=%0b closed=%0b pending=%0d",
                         $time, o_out_valid, o_out_byte, o_last_of_run, o_stream_closed,
                         o_pending_bytes);
                failures = failures + 1;
            end else begin
                oldest = delivery_q.pop_front();
                if (o_out_valid !== oldest.valid || o_out_byte !== oldest.data ||
                    o_last_of_run !== oldest.last || o_stream_closed !== oldest.closed ||
                    o_pending_bytes !== oldest.pending) begin
                    $display("%0t: mismatch: expected valid=%0b byte=%02h last=%0b closed=%0b pending=%0d",
                             $time, oldest.valid, oldest.data, oldest.last, oldest.closed,
                             oldest.pending);
                    $display("%0t:           actual valid=%0b byte=%02h last=%0b closed=%0b pending=%0d",
                             $time, o_out_valid, o_out_byte, o_last_of_run, o_stream_closed,
                             o_pending_bytes);
                    failures = failures + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

// ===== stream_byte_reassembler_core.f =====
sv/srb_pkg.sv
sv/srb_ram.sv
sv/stream_byte_reassembler_core.sv
tb/tb.sv
